// File: rtl/core/voice_session_mode_controller_macros.svh
// Assertion macros for the voice session mode controller.
`ifndef VOICE_SESSION_MODE_CONTROLLER_MACROS_SVH
`define VOICE_SESSION_MODE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

`define VSMC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsmc implication check failed");

`define VSMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsmc next-cycle check failed");

`else

`define VSMC_ASSERT_IMPL(label, clk, rst, ante, cons)

`define VSMC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/vsmc_pkg.sv
// Types and constants of the voice session mode controller.
package vsmc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_LISTEN  = 3'd1,
    MODE_SILENCE = 3'd2,
    MODE_PROC    = 3'd3,
    MODE_SPEAK   = 3'd4,
    MODE_SLEEP   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    DISP_IDLE    = 3'd0,
    DISP_LISTEN  = 3'd1,
    DISP_PROC    = 3'd2,
    DISP_SPEAK   = 3'd3,
    DISP_SLEEP   = 3'd4,
    DISP_OFFLINE = 3'd5
  } disp_t;

  typedef enum logic [3:0] {
    OP_SLEEP_NOW   = 4'd0,
    OP_SLEEP       = 4'd1,
    OP_LINK_DOWN   = 4'd2,
    OP_LINK_UP     = 4'd3,
    OP_VOICE_START = 4'd4,
    OP_VOICE_END   = 4'd5,
    OP_TTS_CHUNK   = 4'd6,
    OP_TTS_END     = 4'd7,
    OP_WAKE        = 4'd8,
    OP_TICK        = 4'd9
  } opcode_t;

  localparam int unsigned ACT_W = 9;
  typedef logic [ACT_W-1:0] act_t;

  localparam act_t ACT_INTERRUPT = 9'h001;
  localparam act_t ACT_EOS       = 9'h002;
  localparam act_t ACT_CLEAR     = 9'h004;
  localparam act_t ACT_STOP      = 9'h008;
  localparam act_t ACT_ASLEEP    = 9'h010;
  localparam act_t ACT_AWAKE     = 9'h020;
  localparam act_t ACT_DSLEEP    = 9'h040;
  localparam act_t ACT_DWAKE     = 9'h080;
  localparam act_t ACT_FLUSH     = 9'h100;

  localparam int unsigned CFG_W = 16;
  localparam logic CFG_SILENCE_TIMEOUT = 1'b0;
  localparam logic CFG_POLL_PERIOD     = 1'b1;
  localparam logic [CFG_W-1:0] SILENCE_TIMEOUT_RST = 16'd1500;
  localparam logic [CFG_W-1:0] POLL_PERIOD_RST     = 16'd100;

  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 16;

  function automatic disp_t disp_of_mode(mode_t m);
    disp_t d;
    unique case (m)
      MODE_IDLE:    d = DISP_IDLE;
      MODE_LISTEN:  d = DISP_LISTEN;
      MODE_SILENCE: d = DISP_LISTEN;
      MODE_PROC:    d = DISP_PROC;
      MODE_SPEAK:   d = DISP_SPEAK;
      MODE_SLEEP:   d = DISP_SLEEP;
      default:      d = DISP_IDLE;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/core/voice_session_mode_controller.sv
// Voice session mode controller: event-driven mode state, timers and output register.
//
// Input channel s_*: one event per transfer (opcode, link status, playback done).
// A tick event counts one millisecond for the silence and poll timers.
// Output channel m_*: one result per event (mode, display update/mode, actions).
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (0 silence timeout, 1 poll period) at the clock edge; no read-back.
// The event is decided by combinational logic on the registered state and the
// result lands in the output register.
// Throughput is one event per cycle, set by the single output register:
// s_tready is high while that register is empty or being drained.
// When the receiver stalls, the result holds and s_tready drops until it is taken.
// Reset (rst, synchronous) returns to idle, clears flags and timers, empties
// the output register and loads the register defaults 1500 and 100.
`include "voice_session_mode_controller_macros.svh"

module voice_session_mode_controller #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [3:0] opcode, [4] link_connected, [5] playback_done, [7:6] zero
  input  logic [vsmc_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [2:0] mode, [3] display_update, [6:4] display_mode, [15:7] actions
  output logic [vsmc_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [vsmc_pkg::CFG_W-1:0]  cfg_data
);
  import vsmc_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

  logic [CFG_W-1:0] silence_timeout;
  logic [CFG_W-1:0] poll_period;

  mode_t                 mode, mode_next;
  logic                  sleep_deferred, sleep_deferred_next;
  logic                  sleep_by_user, sleep_by_user_next;
  logic                  silence_armed, silence_armed_next;
  logic [TIMER_BITS-1:0] silence_count, silence_count_next;
  logic                  poll_armed, poll_armed_next;
  logic [TIMER_BITS-1:0] poll_count, poll_count_next;

  logic                  disp_upd;
  disp_t                 disp_val;
  act_t                  act;

  opcode_t               op;
  logic                  link;
  logic                  done;
  logic                  accept;
  logic [TIMER_BITS-1:0] silence_inc;
  logic [TIMER_BITS-1:0] poll_inc;
  logic                  silence_fire;
  logic                  poll_fire;

  assign op       = opcode_t'(s_tdata[3:0]);
  assign link     = s_tdata[4];
  assign done     = s_tdata[5];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign silence_inc  = (silence_count == CNT_MAX) ? CNT_MAX : silence_count + 1'b1;
  assign poll_inc     = (poll_count == CNT_MAX) ? CNT_MAX : poll_count + 1'b1;
  assign silence_fire = CMP_W'(silence_inc) >= CMP_W'(silence_timeout);
  assign poll_fire    = CMP_W'(poll_inc) >= CMP_W'(poll_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_timeout <= SILENCE_TIMEOUT_RST;
      poll_period     <= POLL_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SILENCE_TIMEOUT: silence_timeout <= cfg_data;
        CFG_POLL_PERIOD:     poll_period     <= cfg_data;
        default:             ;
      endcase
    end
  end

  always_comb begin
    mode_next           = mode;
    sleep_deferred_next = sleep_deferred;
    sleep_by_user_next  = sleep_by_user;
    silence_armed_next  = silence_armed;
    silence_count_next  = silence_count;
    poll_armed_next     = poll_armed;
    poll_count_next     = poll_count;
    disp_upd            = 1'b0;
    disp_val            = DISP_IDLE;
    act                 = '0;

    priority if (op == OP_SLEEP_NOW && mode != MODE_SLEEP) begin
      if (mode == MODE_SPEAK || mode == MODE_PROC) begin
        act = act | ACT_INTERRUPT;
      end
      sleep_by_user_next = 1'b1;
      silence_armed_next = 1'b0;
      silence_count_next = '0;
      poll_armed_next    = 1'b0;
      poll_count_next    = '0;
      act       = act | ACT_STOP | ACT_ASLEEP | ACT_DSLEEP | ACT_FLUSH;
      mode_next = MODE_SLEEP;
      disp_upd  = 1'b1;
      disp_val  = DISP_SLEEP;
    end else if (op == OP_SLEEP && mode != MODE_SLEEP) begin
      if (mode == MODE_SPEAK) begin
        sleep_deferred_next = 1'b1;
      end else begin
        silence_armed_next = 1'b0;
        silence_count_next = '0;
        poll_armed_next    = 1'b0;
        poll_count_next    = '0;
        act       = ACT_STOP | ACT_ASLEEP | ACT_DSLEEP;
        mode_next = MODE_SLEEP;
        disp_upd  = 1'b1;
        disp_val  = DISP_SLEEP;
      end
    end else if (op == OP_LINK_DOWN) begin
      if (mode == MODE_SPEAK) begin
        poll_armed_next = 1'b0;
        poll_count_next = '0;
        act       = ACT_STOP;
        mode_next = MODE_IDLE;
        disp_upd  = 1'b1;
        disp_val  = DISP_OFFLINE;
      end else if (mode == MODE_PROC) begin
        mode_next = MODE_IDLE;
        disp_upd  = 1'b1;
        disp_val  = DISP_OFFLINE;
      end else if (mode == MODE_IDLE) begin
        disp_upd  = 1'b1;
        disp_val  = DISP_OFFLINE;
      end
    end else if (op == OP_LINK_UP) begin
      if (mode == MODE_PROC) begin
        poll_armed_next = 1'b0;
        poll_count_next = '0;
        mode_next = MODE_IDLE;
        disp_upd  = 1'b1;
        disp_val  = DISP_IDLE;
      end else if (mode == MODE_IDLE) begin
        disp_upd  = 1'b1;
        disp_val  = DISP_IDLE;
      end
    end else if (op == OP_TICK) begin
      if (silence_armed) begin
        silence_count_next = silence_inc;
        if (silence_fire) begin
          silence_armed_next = 1'b0;
          silence_count_next = '0;
          if (mode == MODE_SILENCE) begin
            disp_upd = 1'b1;
            if (link) begin
              act       = act | ACT_EOS;
              mode_next = MODE_PROC;
              disp_val  = DISP_PROC;
            end else begin
              act       = act | ACT_CLEAR;
              mode_next = MODE_IDLE;
              disp_val  = DISP_OFFLINE;
            end
          end
        end
      end
      if (poll_armed) begin
        poll_count_next = poll_inc;
        if (poll_fire) begin
          poll_count_next = '0;
          if (done && mode == MODE_SPEAK) begin
            poll_armed_next = 1'b0;
            disp_upd        = 1'b1;
            if (sleep_deferred) begin
              sleep_deferred_next = 1'b0;
              silence_armed_next  = 1'b0;
              silence_count_next  = '0;
              poll_count_next     = '0;
              act       = act | ACT_STOP | ACT_ASLEEP | ACT_DSLEEP;
              mode_next = MODE_SLEEP;
              disp_val  = DISP_SLEEP;
            end else begin
              mode_next = MODE_IDLE;
              disp_val  = DISP_IDLE;
            end
          end
        end
      end
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          if (op == OP_VOICE_START) begin
            act       = ACT_CLEAR;
            mode_next = MODE_LISTEN;
          end else if (op == OP_TTS_CHUNK) begin
            mode_next = MODE_SPEAK;
          end
        end
        MODE_LISTEN: begin
          if (op == OP_VOICE_END) begin
            silence_armed_next = 1'b1;
            silence_count_next = '0;
            mode_next = MODE_SILENCE;
          end
        end
        MODE_SILENCE: begin
          if (op == OP_VOICE_START) begin
            silence_armed_next = 1'b0;
            silence_count_next = '0;
            mode_next = MODE_LISTEN;
          end
        end
        MODE_PROC: begin
          if (op == OP_VOICE_START) begin
            act       = ACT_INTERRUPT | ACT_CLEAR;
            mode_next = MODE_LISTEN;
          end else if (op == OP_TTS_CHUNK) begin
            mode_next = MODE_SPEAK;
          end else if (op == OP_TTS_END) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_SPEAK: begin
          if (op == OP_VOICE_START) begin
            poll_armed_next = 1'b0;
            poll_count_next = '0;
            act       = ACT_STOP | ACT_INTERRUPT;
            mode_next = MODE_LISTEN;
          end else if (op == OP_TTS_END) begin
            poll_armed_next = 1'b1;
            poll_count_next = '0;
          end
        end
        MODE_SLEEP: begin
          if (op == OP_WAKE) begin
            sleep_by_user_next = 1'b0;
            act       = ACT_AWAKE | ACT_DWAKE;
            mode_next = MODE_IDLE;
          end else if (op == OP_TTS_CHUNK && !sleep_by_user) begin
            act       = ACT_AWAKE | ACT_DWAKE;
            mode_next = MODE_SPEAK;
          end
        end
        default: ;
      endcase
      if (mode_next != mode) begin
        disp_upd = 1'b1;
        disp_val = disp_of_mode(mode_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      sleep_deferred <= 1'b0;
      sleep_by_user  <= 1'b0;
      silence_armed  <= 1'b0;
      silence_count  <= '0;
      poll_armed     <= 1'b0;
      poll_count     <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      sleep_deferred <= sleep_deferred_next;
      sleep_by_user  <= sleep_by_user_next;
      silence_armed  <= silence_armed_next;
      silence_count  <= silence_count_next;
      poll_armed     <= poll_armed_next;
      poll_count     <= poll_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {act, disp_val, disp_upd, mode_next};
    end
  end

  `VSMC_ASSERT_IMPL(a_silence_in_wait, clk, rst, silence_armed, mode == MODE_SILENCE)
  `VSMC_ASSERT_IMPL(a_poll_in_speak, clk, rst, poll_armed, mode == MODE_SPEAK)
  `VSMC_ASSERT_IMPL(a_user_sleep, clk, rst, sleep_by_user, mode == MODE_SLEEP)
  `VSMC_ASSERT_IMPL(a_silence_idle_zero, clk, rst, !silence_armed, silence_count == '0)
  `VSMC_ASSERT_NEXT(a_result_follows, clk, rst, accept, m_tvalid)

endmodule

// File: tb/sv/voice_session_mode_checker.sv
// Checker for the voice session mode controller: predicts each result and compares it.
`timescale 1ns / 100ps

module voice_session_mode_checker #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [vsmc_pkg::IN_W-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [vsmc_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [vsmc_pkg::CFG_W-1:0] cfg_data,
  output int                         failures,
  output int                         reports_due
);
  import vsmc_pkg::*;

  typedef logic [TIMER_BITS-1:0] timer_t;

  // Same bit order as m_tdata, lowest field last.
  typedef struct packed {
    act_t  acts;
    disp_t disp;
    logic  upd;
    mode_t mode;
  } mode_report_t;

  mode_report_t reports_q[$];
  mode_report_t outcome;
  mode_report_t want;
  mode_report_t got;

  mode_t            cur_mode;
  logic             sleep_deferred;
  logic             sleep_by_user;
  logic             sil_armed;
  logic             poll_armed;
  timer_t           sil_cnt;
  timer_t           poll_cnt;
  logic [CFG_W-1:0] sil_limit;
  logic [CFG_W-1:0] poll_limit;

  initial failures = 0;
  initial reports_due = 0;

  function automatic timer_t bump(timer_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic disp_t face_of(mode_t m);
    case (m)
      MODE_LISTEN, MODE_SILENCE: return DISP_LISTEN;
      MODE_PROC:                 return DISP_PROC;
      MODE_SPEAK:                return DISP_SPEAK;
      MODE_SLEEP:                return DISP_SLEEP;
      default:                   return DISP_IDLE;
    endcase
  endfunction

  function automatic int field_bad(string name, logic [ACT_W-1:0] exp_v,
                                   logic [ACT_W-1:0] act_v);
    if (act_v === exp_v) return 0;
    $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    return 1;
  endfunction

  task automatic show(disp_t d);
    outcome.upd = 1'b1;
    outcome.disp = d;
  endtask

  task automatic go_mode(mode_t m);
    cur_mode = m;
    show(face_of(m));
  endtask

  task automatic fall_asleep();
    sil_armed = 1'b0;
    sil_cnt = '0;
    poll_armed = 1'b0;
    poll_cnt = '0;
    outcome.acts |= ACT_STOP | ACT_ASLEEP | ACT_DSLEEP;
    go_mode(MODE_SLEEP);
  endtask

  task automatic count_tick(logic link, logic done);
    if (sil_armed) begin
      sil_cnt = bump(sil_cnt);
      if (sil_cnt >= sil_limit) begin
        sil_armed = 1'b0;
        sil_cnt = '0;
        if (cur_mode == MODE_SILENCE) begin
          if (link) begin
            outcome.acts |= ACT_EOS;
            go_mode(MODE_PROC);
          end else begin
            outcome.acts |= ACT_CLEAR;
            cur_mode = MODE_IDLE;
            show(DISP_OFFLINE);
          end
        end
      end
    end
    if (poll_armed) begin
      poll_cnt = bump(poll_cnt);
      if (poll_cnt >= poll_limit) begin
        poll_cnt = '0;
        if (done && cur_mode == MODE_SPEAK) begin
          poll_armed = 1'b0;
          if (sleep_deferred) begin
            sleep_deferred = 1'b0;
            fall_asleep();
          end else begin
            go_mode(MODE_IDLE);
          end
        end
      end
    end
  endtask

  task automatic apply_event(logic [3:0] op, logic link, logic done);
    mode_t m;
    m = cur_mode;
    outcome = '0;
    case (op)
      OP_SLEEP_NOW: if (m != MODE_SLEEP) begin
        if (m == MODE_SPEAK || m == MODE_PROC) outcome.acts |= ACT_INTERRUPT;
        sleep_by_user = 1'b1;
        fall_asleep();
        outcome.acts |= ACT_FLUSH;
      end
      OP_SLEEP: if (m != MODE_SLEEP) begin
        if (m == MODE_SPEAK) sleep_deferred = 1'b1;
        else fall_asleep();
      end
      OP_LINK_DOWN: case (m)
        MODE_SPEAK: begin
          poll_armed = 1'b0;
          poll_cnt = '0;
          outcome.acts |= ACT_STOP;
          cur_mode = MODE_IDLE;
          show(DISP_OFFLINE);
        end
        MODE_PROC: begin
          cur_mode = MODE_IDLE;
          show(DISP_OFFLINE);
        end
        MODE_IDLE: show(DISP_OFFLINE);
        default: ;
      endcase
      OP_LINK_UP: if (m == MODE_PROC) begin
        poll_armed = 1'b0;
        poll_cnt = '0;
        go_mode(MODE_IDLE);
      end else if (m == MODE_IDLE) begin
        show(DISP_IDLE);
      end
      OP_TICK: count_tick(link, done);
      default: case (m)
        MODE_IDLE: if (op == OP_VOICE_START) begin
          outcome.acts |= ACT_CLEAR;
          go_mode(MODE_LISTEN);
        end else if (op == OP_TTS_CHUNK) begin
          go_mode(MODE_SPEAK);
        end
        MODE_LISTEN: if (op == OP_VOICE_END) begin
          sil_armed = 1'b1;
          sil_cnt = '0;
          go_mode(MODE_SILENCE);
        end
        MODE_SILENCE: if (op == OP_VOICE_START) begin
          sil_armed = 1'b0;
          sil_cnt = '0;
          go_mode(MODE_LISTEN);
        end
        MODE_PROC: if (op == OP_VOICE_START) begin
          outcome.acts |= ACT_INTERRUPT | ACT_CLEAR;
          go_mode(MODE_LISTEN);
        end else if (op == OP_TTS_CHUNK) begin
          go_mode(MODE_SPEAK);
        end else if (op == OP_TTS_END) begin
          go_mode(MODE_IDLE);
        end
        MODE_SPEAK: if (op == OP_VOICE_START) begin
          poll_armed = 1'b0;
          poll_cnt = '0;
          outcome.acts |= ACT_STOP | ACT_INTERRUPT;
          go_mode(MODE_LISTEN);
        end else if (op == OP_TTS_END) begin
          poll_armed = 1'b1;
          poll_cnt = '0;
        end
        MODE_SLEEP: if (op == OP_WAKE) begin
          sleep_by_user = 1'b0;
          outcome.acts |= ACT_AWAKE | ACT_DWAKE;
          go_mode(MODE_IDLE);
        end else if (op == OP_TTS_CHUNK && !sleep_by_user) begin
          outcome.acts |= ACT_AWAKE | ACT_DWAKE;
          go_mode(MODE_SPEAK);
        end
        default: ;
      endcase
    endcase
    outcome.mode = cur_mode;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_mode = MODE_IDLE;
      sleep_deferred = 1'b0;
      sleep_by_user = 1'b0;
      sil_armed = 1'b0;
      poll_armed = 1'b0;
      sil_cnt = '0;
      poll_cnt = '0;
      sil_limit = SILENCE_TIMEOUT_RST;
      poll_limit = POLL_PERIOD_RST;
      reports_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (reports_q.size() == 0) begin
          $error("result transfer with no event outstanding: %h", m_tdata);
          failures++;
        end else begin
          want = reports_q.pop_front();
          got = mode_report_t'(m_tdata);
          failures += field_bad("mode", ACT_W'(want.mode), ACT_W'(got.mode));
          failures += field_bad("display_update", ACT_W'(want.upd), ACT_W'(got.upd));
          failures += field_bad("display_mode", ACT_W'(want.disp), ACT_W'(got.disp));
          failures += field_bad("actions", want.acts, got.acts);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SILENCE_TIMEOUT) sil_limit = cfg_data;
        else poll_limit = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        apply_event(s_tdata[3:0], s_tdata[4], s_tdata[5]);
        reports_q.push_back(outcome);
      end
    end
    reports_due <= reports_q.size();
  end

endmodule

// File: tb/sv/tb_voice_session_mode_controller.sv
// Testbench top for the voice session mode controller: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_voice_session_mode_controller;
  import vsmc_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  int failures;
  int reports_due;
  int idle_pct = 0;
  int stall_pct = 0;
  int events_sent = 0;
  int quiet_cycles = 0;
  int held = 0;
  int cur_sil = int'(SILENCE_TIMEOUT_RST);
  int cur_poll = int'(POLL_PERIOD_RST);
  logic pressure_on = 1'b0;

  always #5 clk = ~clk;

  voice_session_mode_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  voice_session_mode_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .reports_due(reports_due)
  );

  // Hold off the receiver once for a long stretch when pressure is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (pressure_on && held < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      held <= held + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic int tick_span(int limit);
    return (limit <= 120) ? $urandom_range(limit + 2) : $urandom_range(40);
  endfunction

  task automatic send_event(input logic [3:0] op, input logic link, input logic done);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, done, link, op};
    do @(posedge clk); while (!s_tready);
    events_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_timers(input logic [CFG_W-1:0] sil, input logic [CFG_W-1:0] poll);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SILENCE_TIMEOUT;
    cfg_data  <= sil;
    @(posedge clk);
    cfg_index <= CFG_POLL_PERIOD;
    cfg_data  <= poll;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sil  = int'(sil);
    cur_poll = int'(poll);
  endtask

  // One conversation turn with random timing, link state and barge-ins.
  task automatic talk_turn();
    logic link;
    if ($urandom_range(2) == 0) send_event(OP_WAKE, coin(), coin());
    send_event(OP_VOICE_START, coin(), coin());
    repeat ($urandom_range(3)) send_event(OP_TICK, coin(), coin());
    send_event(OP_VOICE_END, coin(), coin());
    link = ($urandom_range(9) < 7);
    repeat (tick_span(cur_sil)) send_event(OP_TICK, link, coin());
    if ($urandom_range(9) == 0) send_event(OP_LINK_DOWN, coin(), coin());
    if ($urandom_range(9) == 0) send_event(OP_LINK_UP, coin(), coin());
    repeat (1 + $urandom_range(2)) send_event(OP_TTS_CHUNK, coin(), coin());
    if ($urandom_range(6) == 0) send_event(OP_SLEEP, coin(), coin());
    if ($urandom_range(9) == 0) begin
      send_event(OP_VOICE_START, coin(), coin());
    end else begin
      send_event(OP_TTS_END, coin(), coin());
      repeat (tick_span(cur_poll)) send_event(OP_TICK, coin(), $urandom_range(2) == 0);
      if ($urandom_range(7) == 0) send_event(OP_SLEEP_NOW, coin(), coin());
    end
  endtask

  task automatic noise_burst();
    repeat (1 + $urandom_range(5)) send_event(4'($urandom_range(15)), coin(), coin());
  endtask

  task automatic run_phase(input int idle, input int stall, input int sil, input int poll,
                           input int items, input logic squeeze);
    int goal;
    drain();
    set_timers(CFG_W'(sil), CFG_W'(poll));
    idle_pct = idle;
    stall_pct <= stall;
    if (squeeze) pressure_on <= 1'b1;
    goal = events_sent + items;
    while (events_sent < goal) begin
      if ($urandom_range(3) != 0) talk_turn();
      else noise_burst();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_event(4'hF, 1'b1, 1'b1);
    send_event(OP_LINK_DOWN, 1'b0, 1'b0);
    send_event(OP_LINK_UP, 1'b1, 1'b0);
    send_event(OP_SLEEP_NOW, 1'b0, 1'b0);
    send_event(OP_SLEEP, 1'b0, 1'b0);
    send_event(OP_TTS_CHUNK, 1'b0, 1'b0);
    send_event(OP_WAKE, 1'b0, 1'b0);
    drain();
    // Zero periods: both timers fire at the first tick.
    set_timers('0, '0);
    send_event(OP_VOICE_START, 1'b0, 1'b0);
    send_event(OP_VOICE_END, 1'b0, 1'b0);
    send_event(OP_TICK, 1'b0, 1'b0);
    send_event(OP_VOICE_START, 1'b1, 1'b0);
    send_event(OP_VOICE_END, 1'b1, 1'b0);
    send_event(OP_TICK, 1'b1, 1'b0);
    send_event(OP_VOICE_START, 1'b1, 1'b0);
    send_event(OP_VOICE_END, 1'b1, 1'b0);
    send_event(OP_TICK, 1'b1, 1'b0);
    send_event(OP_LINK_DOWN, 1'b0, 1'b0);
    send_event(OP_TTS_CHUNK, 1'b1, 1'b0);
    // Deferred sleep survives a sleep_now and fires at the next playback completion.
    send_event(OP_SLEEP, 1'b1, 1'b0);
    send_event(OP_SLEEP_NOW, 1'b1, 1'b0);
    send_event(OP_WAKE, 1'b1, 1'b0);
    send_event(OP_TTS_CHUNK, 1'b1, 1'b0);
    send_event(OP_TTS_END, 1'b1, 1'b0);
    send_event(OP_TICK, 1'b1, 1'b1);
    send_event(OP_TTS_CHUNK, 1'b1, 1'b1);
    send_event(OP_LINK_DOWN, 1'b1, 1'b1);

    run_phase(0, 0, 1, 1, 250, 1'b0);
    run_phase(52, 0, 5, 3, 250, 1'b0);
    run_phase(0, 52, 12, 7, 250, 1'b0);
    run_phase(8, 8, 65535, 65535, 150, 1'b0);
    run_phase(0, 0, 4, 5, 120, 1'b1);
    run_phase(52, 0, 0, 2, 250, 1'b0);
    run_phase(0, 52, 1500, 100, 250, 1'b0);
    run_phase(8, 8, 2, 0, 250, 1'b0);

    drain();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
